// ===== hw/rtl/closest_pair_brute_force_top_assert.svh =====
// ---------------------------------------------------------------------------
// closest pair assertion macros
// shared assertion forms, all clocked on clk and disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef CLOSEST_PAIR_BRUTE_FORCE_TOP_ASSERT_SVH
`define CLOSEST_PAIR_BRUTE_FORCE_TOP_ASSERT_SVH

// condition holds at every edge
`define CPBF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle
`define CPBF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds in the next cycle
`define CPBF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cpbf_pkg.sv =====
// ---------------------------------------------------------------------------
// closest pair package
// default sizes shared by the closest pair modules
// ---------------------------------------------------------------------------
`default_nettype none

package cpbf_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

endpackage

`default_nettype wire

// ===== hw/rtl/cpbf_ram.sv =====
// ---------------------------------------------------------------------------
// generic ram
// one write port, one read port, read data registered
// ---------------------------------------------------------------------------
`default_nettype none

module cpbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cpbf_dist.sv =====
// ---------------------------------------------------------------------------
// squared distance pipeline
// three stages: absolute differences, squares, sum; points travel alongside
// ---------------------------------------------------------------------------
`default_nettype none

module cpbf_dist #(
  parameter int COORD_BITS = cpbf_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  output logic                              out_valid,
  output logic        [4*COORD_BITS-1:0]    out_pts,  // ax, ay, bx, by from lsb
  output logic        [2*COORD_BITS:0]      out_sq,
  output logic                              busy
);

  localparam int C = COORD_BITS;

  logic signed [C:0]   dx, dy;
  logic        [C:0]   adx, ady;

  logic                v1, v2;
  logic [C-1:0]        abs_x, abs_y;
  logic [4*C-1:0]      pts1, pts2;
  logic [2*C-1:0]      sq_x, sq_y;

  always_comb begin
    dx  = (C+1)'(ax) - (C+1)'(bx);
    dy  = (C+1)'(ay) - (C+1)'(by);
    adx = dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
    ady = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    abs_x   <= adx[C-1:0];
    abs_y   <= ady[C-1:0];
    pts1    <= {by, bx, ay, ax};
    sq_x    <= abs_x * abs_x;
    sq_y    <= abs_y * abs_y;
    pts2    <= pts1;
    // two squares of at most 2^C-1 never overflow 2C+1 bits
    out_sq  <= (2*C+1)'(sq_x) + (2*C+1)'(sq_y);
    out_pts <= pts2;
  end

  assign busy = v1 | v2 | out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/cpbf_sqrt.sv =====
// ---------------------------------------------------------------------------
// fixed point square root
// digit-by-digit root, one result bit per cycle, fraction bits appended
// ---------------------------------------------------------------------------
`default_nettype none

module cpbf_sqrt #(
  parameter int COORD_BITS = cpbf_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = cpbf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [2*COORD_BITS:0]             radicand,
  output logic                                   busy,
  output logic      [COORD_BITS+FRAC_BITS:0]     root
);

  localparam int DIST_BITS = COORD_BITS + 1 + FRAC_BITS;
  localparam int RAD_W     = 2*DIST_BITS;
  localparam int REM_W     = DIST_BITS + 2;
  localparam int CNT_W     = $clog2(DIST_BITS + 1);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem_sh, trial;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end

    if (start) begin
      rad  <= RAD_W'(radicand) << (2*FRAC_BITS);
      rem  <= '0;
      root <= '0;
      cnt  <= CNT_W'(DIST_BITS);
    end else if (busy) begin
      rad <= rad << 2;
      cnt <= cnt - CNT_W'(1);
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[DIST_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[DIST_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/closest_pair_brute_force_top.sv =====
// ---------------------------------------------------------------------------
// closest pair of points, brute force
// stores a set of points and reports the closest pair once the set ends
// ---------------------------------------------------------------------------
// usage:
//   points arrive on the s_ channel, one per transaction; s_tlast marks the
//   final point of a set and starts the search. one result per set leaves on
//   the m_ channel: the closest pair (earliest on ties), its squared distance
//   and the distance in fixed point. m_tuser carries pair_valid and
//   overflowed. points beyond MAX_POINTS are dropped and flagged.
// timing:
//   loading accepts one point per cycle. the search reads point i once and then
//   streams the later points through the single read port of the point ram;
//   when a pair was found, the root unit then yields the distance one bit a
//   cycle, and the result register is loaded. while searching, s_tready is low.
// reset and stall:
//   rst clears the point count, overflow flag and output valid; the ram is not
//   cleared. the result sits in an output register; the next set loads while
//   it waits, and a finished search holds until m_tready frees that register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "closest_pair_brute_force_top_assert.svh"

module closest_pair_brute_force_top #(
  parameter int MAX_POINTS = cpbf_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cpbf_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = cpbf_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = ((2*COORD_BITS + 7) / 8) * 8,
  localparam int OUT_F = 7*COORD_BITS + 2 + FRAC_BITS,
  localparam int OUT_W = ((OUT_F + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // point_x, point_y, zero pad
  input  wire logic             s_tlast,   // last_point
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // first_x, first_y, second_x, second_y, squared_distance, distance_fixed, pad
  output logic      [OUT_W-1:0] m_tdata,
  output logic      [1:0]       m_tuser    // pair_valid, overflowed
);

  localparam int C         = COORD_BITS;
  localparam int AW        = $clog2(MAX_POINTS);
  localparam int CW        = $clog2(MAX_POINTS + 1);
  localparam int SQ_BITS   = 2*C + 1;
  localparam int DIST_BITS = C + 1 + FRAC_BITS;

  typedef enum logic [2:0] {
    S_LOAD, S_RDI, S_LATI, S_SCAN, S_DRAIN, S_SQRT, S_FIN
  } state_t;

  state_t state;

  logic [CW-1:0] count, cnt_after, i, j;
  logic          ovf, found, rd_pend;
  logic          accept, room;

  logic            ram_wr_en, ram_rd_en;
  logic [AW-1:0]   ram_rd_addr;
  logic [2*C-1:0]  ram_rd_data;

  logic signed [C-1:0] pi_x, pi_y;

  logic                d_valid, dist_busy;
  logic [4*C-1:0]      d_pts, best_pts;
  logic [SQ_BITS-1:0]  d_sq, best_sq;

  logic                 sqrt_start, sqrt_busy;
  logic [DIST_BITS-1:0] sqrt_root;

  logic [OUT_F-1:0] out_pack;
  logic             out_free, better, drain_done;

  assign accept     = s_tvalid && s_tready;
  assign s_tready   = (state == S_LOAD);
  assign room       = count < CW'(MAX_POINTS);
  assign cnt_after  = count + CW'(room);
  assign ram_wr_en  = accept && room;
  assign out_free   = !m_tvalid || m_tready;
  assign better     = d_valid && (!found || d_sq < best_sq);
  assign drain_done = !rd_pend && !dist_busy;
  assign sqrt_start = (state == S_DRAIN) && drain_done && found;

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = j[AW-1:0];
    case (state)
      S_RDI: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = i[AW-1:0];
      end
      S_LATI: ram_rd_en = 1'b1;
      S_SCAN: ram_rd_en = j < count;
      default: ram_rd_en = 1'b0;
    endcase
  end

  cpbf_ram #(
    .WIDTH (2*C),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (s_tdata[2*C-1:0]),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  cpbf_dist #(
    .COORD_BITS (C)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_pend),
    .ax        (pi_x),
    .ay        (pi_y),
    .bx        (ram_rd_data[C-1:0]),
    .by        (ram_rd_data[2*C-1:C]),
    .out_valid (d_valid),
    .out_pts   (d_pts),
    .out_sq    (d_sq),
    .busy      (dist_busy)
  );

  cpbf_sqrt #(
    .COORD_BITS (C),
    .FRAC_BITS  (FRAC_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (best_sq),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  // all fields zero when fewer than two points were stored
  assign out_pack = found ? {sqrt_root, best_sq, best_pts} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      found    <= 1'b0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= ram_rd_en && (state != S_RDI);
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      if (better) begin
        found <= 1'b1;
      end

      case (state)
        S_LOAD: begin
          if (accept) begin
            count <= cnt_after;
            if (!room) begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              i     <= '0;
              state <= (cnt_after < CW'(2)) ? S_FIN : S_RDI;
            end
          end
        end
        S_RDI: begin
          j     <= i + CW'(1);
          state <= S_LATI;
        end
        S_LATI: begin
          pi_x  <= ram_rd_data[C-1:0];
          pi_y  <= ram_rd_data[2*C-1:C];
          j     <= j + CW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (j < count) begin
            j <= j + CW'(1);
          end else if ((CW+1)'(i) + (CW+1)'(2) < (CW+1)'(count)) begin
            i     <= i + CW'(1);
            state <= S_RDI;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_done) begin
            state <= found ? S_SQRT : S_FIN;
          end
        end
        S_SQRT: begin
          if (!sqrt_busy) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'(out_pack);
            m_tuser  <= {ovf, found};
            count    <= '0;
            ovf      <= 1'b0;
            found    <= 1'b0;
            state    <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end

    if (better) begin
      best_sq  <= d_sq;
      best_pts <= d_pts;
    end
  end

  `CPBF_ASSERT_ALWAYS(a_count_bound, count <= CW'(MAX_POINTS), "point count beyond capacity")
  `CPBF_ASSERT_IMP(a_write_in_load, ram_wr_en, state == S_LOAD, "ram write outside load")
  `CPBF_ASSERT_IMP(a_pipe_idle_load, state == S_LOAD, !rd_pend && !dist_busy, "search active in load")
  `CPBF_ASSERT_NXT(a_sqrt_runs, sqrt_start, sqrt_busy && state == S_SQRT, "root unit not started")
  `CPBF_ASSERT_IMP(a_no_pair_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "invalid result not zero")

endmodule

`default_nettype wire

// ===== tb/closest_pair_brute_force_top_test.sv =====
// ---------------------------------------------------------------------------
// closest pair brute force testbench
// streams sets of points into the block and checks every result against a
// local closest pair search: first pair on ties, exact squared distance and
// truncated fixed point root, pair_valid for short sets and the overflow
// flag for sets longer than the store; random idling on both sides, one long
// output stall and one drain pause
// ---------------------------------------------------------------------------
`default_nettype none

module closest_pair_brute_force_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS    = cpbf_pkg::MAX_POINTS_DEF;
  localparam int COORD      = cpbf_pkg::COORD_BITS_DEF;
  localparam int FRAC       = cpbf_pkg::FRAC_BITS_DEF;
  localparam int IN_W       = ((2*COORD + 7) / 8) * 8;
  localparam int OUT_W      = ((7*COORD + 2 + FRAC + 7) / 8) * 8;
  localparam int SQ_W       = 2*COORD + 1;
  localparam int DIST_W     = COORD + 1 + FRAC;
  localparam int SQ_LO      = 4*COORD;
  localparam int DIST_LO    = SQ_LO + SQ_W;
  localparam int ITEM_TOTAL = 1400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_MAX = 10;

  typedef logic [COORD-1:0] coord_t;

  typedef struct packed {
    coord_t              first_x;
    coord_t              first_y;
    coord_t              second_x;
    coord_t              second_y;
    logic [SQ_W-1:0]     sq_dist;
    logic [DIST_W-1:0]   dist_fixed;
    logic                pair_valid;
    logic                overflowed;
  } closest_pair_t;

  class closest_pair_scoreboard;
    coord_t        set_x[$];
    coord_t        set_y[$];
    bit            set_dropped;
    closest_pair_t awaited[$];
    int            mismatches;

    function int outstanding();
      return awaited.size();
    endfunction

    // floor(sqrt(sq * 2^(2*FRAC))) one result bit at a time
    function logic [DIST_W-1:0] fixed_root(logic [SQ_W-1:0] sq);
      logic [63:0] scaled;
      logic [63:0] root;
      logic [63:0] cand;
      scaled = 64'(sq) << (2*FRAC);
      root = '0;
      for (int b = DIST_W - 1; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= scaled) root = cand;
      end
      return root[DIST_W-1:0];
    endfunction

    function closest_pair_t search_closest();
      closest_pair_t r;
      longint dx, dy, d, best;
      bit found;
      r = '0;
      found = 0;
      best = 0;
      for (int i = 0; i < set_x.size(); i++) begin
        for (int j = i + 1; j < set_x.size(); j++) begin
          dx = longint'($signed(set_x[i])) - longint'($signed(set_x[j]));
          dy = longint'($signed(set_y[i])) - longint'($signed(set_y[j]));
          d = dx*dx + dy*dy;
          // strict compare keeps the earliest pair on ties
          if (!found || d < best) begin
            found = 1;
            best = d;
            r.first_x = set_x[i];
            r.first_y = set_y[i];
            r.second_x = set_x[j];
            r.second_y = set_y[j];
          end
        end
      end
      if (found) begin
        r.sq_dist = best[SQ_W-1:0];
        r.dist_fixed = fixed_root(r.sq_dist);
        r.pair_valid = 1'b1;
      end
      r.overflowed = set_dropped;
      return r;
    endfunction

    function void note_point(coord_t x, coord_t y, logic last);
      if (set_x.size() < MAX_PTS) begin
        set_x.push_back(x);
        set_y.push_back(y);
      end else begin
        set_dropped = 1;
      end
      if (last) begin
        awaited.push_back(search_closest());
        set_x.delete();
        set_y.delete();
        set_dropped = 0;
      end
    endfunction

    function void field_check(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch %s: expected %0h actual %0h", name, e, a);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic [1:0] user);
      closest_pair_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: tdata %0h tuser %0h", data, user);
        return;
      end
      e = awaited.pop_front();
      field_check("first_x", e.first_x, data[0 +: COORD]);
      field_check("first_y", e.first_y, data[COORD +: COORD]);
      field_check("second_x", e.second_x, data[2*COORD +: COORD]);
      field_check("second_y", e.second_y, data[3*COORD +: COORD]);
      field_check("squared_distance", e.sq_dist, data[SQ_LO +: SQ_W]);
      field_check("distance_fixed", e.dist_fixed, data[DIST_LO +: DIST_W]);
      field_check("pair_valid", e.pair_valid, user[0]);
      field_check("overflowed", e.overflowed, user[1]);
    endfunction
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // point_x, point_y
  logic             s_tlast = 1'b0; // last_point
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // first_x, first_y, second_x, second_y, squared_distance, distance_fixed, pad
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;        // pair_valid, overflowed

  closest_pair_scoreboard sb = new();
  int items_sent = 0;
  int rx_hold = 0;
  bit quiet = 0;

  closest_pair_brute_force_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // output side: long hold on request, otherwise random stall bursts
  initial begin
    int idle_left;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(1, 8) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  task automatic send_point(input coord_t x, input coord_t y, input logic last,
                            input bit gaps);
    if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_point(x, y, last);
    items_sent++;
    if (items_sent > ITEM_TOTAL - 200) quiet = 1;
  endtask

  function automatic coord_t pick_coord(int mode, coord_t base);
    case (mode)
      0: return coord_t'($urandom);
      1: return base + coord_t'($urandom_range(0, 7));
      default: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(COORD-1){1'b0}}};
          1: return {1'b0, {(COORD-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_set(input int n);
    int mode;
    bit gaps;
    coord_t base_x, base_y;
    mode = $urandom_range(0, 4);
    if (mode > 2) mode = 1;   // clustered sets give ties and duplicates
    gaps = ($urandom_range(0, 3) != 0);
    base_x = coord_t'($urandom);
    base_y = coord_t'($urandom);
    for (int k = 0; k < n; k++)
      send_point(pick_coord(mode, base_x), pick_coord(mode, base_y), k == n - 1, gaps);
  endtask

  initial begin
    int sets;
    int pick;
    int n;
    sets = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // opposite corners, the largest distance
    send_point(16'h8000, 16'h8000, 1'b0, 1'b1);
    send_point(16'h7fff, 16'h7fff, 1'b1, 1'b1);
    send_point(16'h7fff, 16'h8000, 1'b0, 1'b1);
    send_point(16'h8000, 16'h7fff, 1'b1, 1'b1);
    // lone point, no pair
    send_point(16'hffff, 16'hffff, 1'b1, 1'b1);
    // equal spacing, earliest pair must win
    send_point(16'd0, 16'd0, 1'b0, 1'b1);
    send_point(16'd1, 16'd0, 1'b0, 1'b1);
    send_point(16'd2, 16'd0, 1'b0, 1'b1);
    send_point(16'd3, 16'd0, 1'b1, 1'b1);
    // duplicate points, zero distance across a gap
    send_point(16'd5, 16'd5, 1'b0, 1'b1);
    send_point(16'd100, 16'hff9c, 1'b0, 1'b1);
    send_point(16'd5, 16'd5, 1'b1, 1'b1);
    // root with a fraction
    send_point(16'hfffe, 16'd7, 1'b0, 1'b1);
    send_point(16'd1, 16'd9, 1'b1, 1'b1);

    while (items_sent < ITEM_TOTAL) begin
      if (sets == 0) begin
        // output held for a long time while input keeps coming
        rx_hold = 400;
        n = 3;
      end else if (sets == 1) begin
        n = 68;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 3) n = $urandom_range(MAX_PTS + 1, MAX_PTS + 8);
        else if (pick < 12) n = $urandom_range(11, MAX_PTS);
        else if (pick < 22) n = $urandom_range(1, 2);
        else n = $urandom_range(3, 10);
      end
      if (sets == 60) begin
        // drain the block before going on
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
      end
      send_random_set(n);
      sets++;
    end
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
